>>> src/rc5_pkg.sv
// Shared types and constants for the RC5-32 cipher block.
package rc5_pkg;

  localparam int WORD_W      = 32;
  localparam int ROT_W       = 5;
  localparam int CMD_W       = 2;
  localparam int ROUNDS_W    = 4;
  localparam int KEY_WORDS   = 4;
  localparam int KEY_IDX_W   = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int PASS_W      = 2;

  localparam logic [WORD_W-1:0]   RC5_P        = 32'hB7E1_5163;
  localparam logic [WORD_W-1:0]   RC5_Q        = 32'h9E37_79B9;
  localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 4'd12;
  localparam logic [ROT_W-1:0]    MIX_A_ROT    = 5'd3;
  // three mixing passes over the table: passes 0, 1, 2
  localparam logic [PASS_W-1:0]   LAST_PASS    = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_3 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ROUNDS     = 3'd4;

  typedef enum logic [CMD_W-1:0] {
    CMD_EXPAND  = 2'd0,
    CMD_ENCRYPT = 2'd1,
    CMD_DECRYPT = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    OP_ADD,   // x + s
    OP_SUB,   // x - s
    OP_ENC,   // rotl(x ^ y, y) + s
    OP_DEC,   // rotr(x - s, y) ^ y
    OP_MIX_A, // rotl(s + x + y, 3)
    OP_MIX_B  // rotl(s + x + y, x + y)
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_MIX_A,
    ST_MIX_B,
    ST_ENC,
    ST_DEC,
    ST_FIN
  } state_t;

endpackage

>>> src/rc5_block_cipher.sv
// RC5-32 block cipher top level: sequencer, subkey RAM and result register.
//
// One shared half-round unit does all the arithmetic, one half-round (or one
// half of a key-mixing step) per clock, and the subkey table sits in a RAM
// with one write port and one registered read port. An encrypt or decrypt block
// accepts its words and prefetches the first subkey, runs 2r+2 half-rounds and
// then loads the result register. An expand command, with t = 2(r+1), seeds
// the t table entries and then runs 3t mixing steps, each as a MIX_A half
// and a MIX_B half. Command 3 returns zeros. The block accepts a new command
// while a finished result still waits at the output.
module rc5_block_cipher
  import rc5_pkg::*;
#(
  parameter int MAX_ROUNDS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [2*WORD_W-1:0]    s_tdata,   // left_in[31:0], right_in[63:32]
  input  logic [CMD_W-1:0]       s_tuser,   // command[1:0]
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [2*WORD_W-1:0]    m_tdata,   // left_out[31:0], right_out[63:32]
  output logic                   m_tuser    // key_ready[0]
);

  localparam int TABLE_DEPTH = 2 * (MAX_ROUNDS + 1);
  localparam int IW          = $clog2(TABLE_DEPTH);

  // configuration registers
  logic [WORD_W-1:0]   key_word [KEY_WORDS];
  logic [ROUNDS_W-1:0] rounds;

  state_t state, state_next;
  logic   table_valid;
  logic   out_valid;
  logic   fin_load;
  logic   accept;
  cmd_t   cmd;

  logic [IW-1:0]        eff_r;
  logic [IW-1:0]        last_idx;
  logic [IW-1:0]        idx;
  logic [IW-1:0]        idx_wrap;
  logic [IW-1:0]        idx_dn;
  logic                 idx_last;
  logic                 first_pair;
  logic                 tgt_b;
  logic [PASS_W-1:0]    pass;
  logic [KEY_IDX_W-1:0] kidx;
  logic                 mix_done;

  logic [WORD_W-1:0] a, b;
  logic [WORD_W-1:0] key_mix [KEY_WORDS];

  // subkey RAM
  logic [WORD_W-1:0] subkeys [TABLE_DEPTH];
  logic [WORD_W-1:0] rd_data;
  logic [IW-1:0]     rd_addr;
  logic              mem_we;
  logic [WORD_W-1:0] wr_data;

  // shared unit
  op_t               alu_op;
  logic [WORD_W-1:0] alu_x, alu_y, alu_s, alu_res;

  logic [WORD_W-1:0] out_left, out_right;
  logic              out_key_ready;

  rc5_alu u_alu (
    .op  (alu_op),
    .x   (alu_x),
    .y   (alu_y),
    .s   (alu_s),
    .res (alu_res)
  );

  // round count clamped to 1..MAX_ROUNDS
  always_comb begin
    priority if (rounds == '0) begin
      eff_r = IW'(1);
    end else if (int'(rounds) > MAX_ROUNDS) begin
      eff_r = IW'(MAX_ROUNDS);
    end else begin
      eff_r = IW'(rounds);
    end
  end

  assign last_idx   = {eff_r[IW-2:0], 1'b1};
  assign idx_last   = (idx == last_idx);
  assign idx_wrap   = idx_last ? '0 : idx + IW'(1);
  assign idx_dn     = (idx == '0) ? '0 : idx - IW'(1);
  assign first_pair = (idx[IW-1:1] == '0);
  assign tgt_b      = idx[0];
  assign mix_done   = idx_last && (pass == LAST_PASS);

  assign cmd      = cmd_t'(s_tuser);
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign fin_load = (state == ST_FIN) && (!out_valid || m_tready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          unique case (cmd)
            CMD_EXPAND:  state_next = ST_SEED;
            CMD_ENCRYPT: state_next = ST_ENC;
            CMD_DECRYPT: state_next = ST_DEC;
            default:     state_next = ST_FIN;
          endcase
        end
      end
      ST_SEED:  if (idx_last) state_next = ST_MIX_A;
      ST_MIX_A: state_next = ST_MIX_B;
      ST_MIX_B: state_next = mix_done ? ST_FIN : ST_MIX_A;
      ST_ENC:   if (idx_last) state_next = ST_FIN;
      ST_DEC:   if (idx == '0) state_next = ST_FIN;
      ST_FIN:   if (!out_valid || m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // datapath controls; read address always runs one step ahead
  always_comb begin
    alu_op  = OP_ADD;
    alu_x   = a;
    alu_y   = b;
    alu_s   = rd_data;
    rd_addr = idx;
    mem_we  = 1'b0;
    wr_data = alu_res;
    unique case (state)
      ST_IDLE: begin
        rd_addr = (cmd == CMD_DECRYPT) ? last_idx : '0;
      end
      ST_SEED: begin
        alu_s   = RC5_Q;
        mem_we  = 1'b1;
        wr_data = a;
        rd_addr = '0;
      end
      ST_MIX_A: begin
        alu_op  = OP_MIX_A;
        mem_we  = 1'b1;
        rd_addr = idx_wrap;
      end
      ST_MIX_B: begin
        alu_op  = OP_MIX_B;
        alu_s   = key_mix[kidx];
        rd_addr = idx_wrap;
      end
      ST_ENC: begin
        alu_op  = first_pair ? OP_ADD : OP_ENC;
        alu_x   = tgt_b ? b : a;
        alu_y   = tgt_b ? a : b;
        rd_addr = idx_wrap;
      end
      ST_DEC: begin
        alu_op  = first_pair ? OP_SUB : OP_DEC;
        alu_x   = tgt_b ? b : a;
        alu_y   = tgt_b ? a : b;
        rd_addr = idx_dn;
      end
      ST_FIN: begin
        rd_addr = '0;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= subkeys[rd_addr];
    if (mem_we) begin
      subkeys[idx] <= wr_data;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < KEY_WORDS; k++) begin
        key_word[k] <= '0;
      end
      rounds <= ROUNDS_RESET;
    end else if (cfg_wr_en) begin
      priority if (cfg_index == REG_ROUNDS) begin
        rounds <= cfg_data[ROUNDS_W-1:0];
      end else if (cfg_index == REG_KEY_WORD_0 || cfg_index == REG_KEY_WORD_1 ||
                   cfg_index == REG_KEY_WORD_2 || cfg_index == REG_KEY_WORD_3) begin
        key_word[cfg_index[KEY_IDX_W-1:0]] <= cfg_data;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      table_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_MIX_B && mix_done) begin
        table_valid <= 1'b1;
      end
      if (fin_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_EXPAND: begin
              a   <= RC5_P;
              b   <= '0;
              idx <= '0;
              for (int k = 0; k < KEY_WORDS; k++) begin
                key_mix[k] <= key_word[k];
              end
            end
            CMD_ENCRYPT: begin
              a   <= s_tdata[WORD_W-1:0];
              b   <= s_tdata[2*WORD_W-1:WORD_W];
              idx <= '0;
            end
            CMD_DECRYPT: begin
              a   <= s_tdata[WORD_W-1:0];
              b   <= s_tdata[2*WORD_W-1:WORD_W];
              idx <= last_idx;
            end
            default: begin
              a <= '0;
              b <= '0;
            end
          endcase
        end
      end
      ST_SEED: begin
        idx <= idx_wrap;
        if (idx_last) begin
          a    <= '0;
          b    <= '0;
          pass <= '0;
          kidx <= '0;
        end else begin
          a <= alu_res;
        end
      end
      ST_MIX_A: begin
        a <= alu_res;
      end
      ST_MIX_B: begin
        key_mix[kidx] <= alu_res;
        kidx          <= kidx + KEY_IDX_W'(1);
        idx           <= idx_wrap;
        if (idx_last) begin
          pass <= pass + PASS_W'(1);
        end
        // expand reports zero words
        if (mix_done) begin
          a <= '0;
          b <= '0;
        end else begin
          b <= alu_res;
        end
      end
      ST_ENC: begin
        if (tgt_b) b <= alu_res;
        else       a <= alu_res;
        idx <= idx_wrap;
      end
      ST_DEC: begin
        if (tgt_b) b <= alu_res;
        else       a <= alu_res;
        idx <= idx_dn;
      end
      ST_FIN: begin
        if (fin_load) begin
          out_left      <= a;
          out_right     <= b;
          out_key_ready <= table_valid;
        end
      end
      default: begin
        idx <= '0;
      end
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_right, out_left};
  assign m_tuser  = out_key_ready;

endmodule

>>> src/rc5_alu.sv
// Shared RC5 half-round unit: add/sub/xor, barrel rotate, add/xor.
module rc5_alu
  import rc5_pkg::*;
(
  input  op_t               op,
  input  logic [WORD_W-1:0] x,
  input  logic [WORD_W-1:0] y,
  input  logic [WORD_W-1:0] s,
  output logic [WORD_W-1:0] res
);

  logic [WORD_W-1:0]   pre;
  logic [ROT_W-1:0]    amt;
  logic [2*WORD_W-1:0] dbl;
  logic [WORD_W-1:0]   rot;

  always_comb begin
    unique case (op)
      OP_ADD: begin
        pre = x + s;
        amt = '0;
      end
      OP_SUB: begin
        pre = x - s;
        amt = '0;
      end
      OP_ENC: begin
        pre = x ^ y;
        amt = y[ROT_W-1:0];
      end
      OP_DEC: begin
        pre = x - s;
        // right rotate expressed as a left rotate by the negated amount
        amt = -y[ROT_W-1:0];
      end
      OP_MIX_A: begin
        pre = s + x + y;
        amt = MIX_A_ROT;
      end
      OP_MIX_B: begin
        pre = s + x + y;
        amt = x[ROT_W-1:0] + y[ROT_W-1:0];
      end
      default: begin
        pre = x;
        amt = '0;
      end
    endcase
  end

  assign dbl = {pre, pre} << amt;
  assign rot = dbl[2*WORD_W-1:WORD_W];

  always_comb begin
    unique case (op)
      OP_ENC:  res = rot + s;
      OP_DEC:  res = rot ^ y;
      default: res = rot;
    endcase
  end

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the RC5-32 block cipher: predictor, scoreboard and stream drivers.

typedef struct {
  logic [rc5_pkg::WORD_W-1:0] left;
  logic [rc5_pkg::WORD_W-1:0] right;
  logic                       key_ready;
} cipher_result_t;

class cipher_scoreboard;
  localparam int MAX_RND = 12;
  localparam int DEPTH   = 2 * (MAX_RND + 1);

  logic [31:0]    key_regs[rc5_pkg::KEY_WORDS];
  logic [3:0]     rounds_reg;
  logic [31:0]    subkeys[DEPTH];
  logic [31:0]    mix_words[rc5_pkg::KEY_WORDS];
  bit             table_valid;
  int unsigned    expanded_rounds;
  cipher_result_t expected_results[$];
  int unsigned    mismatches;
  int unsigned    results_checked;

  function new();
    foreach (key_regs[k]) key_regs[k] = '0;
    foreach (mix_words[k]) mix_words[k] = '0;
    foreach (subkeys[k]) subkeys[k] = '0;
    rounds_reg      = rc5_pkg::ROUNDS_RESET;
    table_valid     = 0;
    expanded_rounds = 0;
    mismatches      = 0;
    results_checked = 0;
  endfunction

  function void write_reg(logic [rc5_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] value);
    case (idx)
      rc5_pkg::REG_KEY_WORD_0: key_regs[0] = value;
      rc5_pkg::REG_KEY_WORD_1: key_regs[1] = value;
      rc5_pkg::REG_KEY_WORD_2: key_regs[2] = value;
      rc5_pkg::REG_KEY_WORD_3: key_regs[3] = value;
      rc5_pkg::REG_ROUNDS:     rounds_reg  = value[3:0];
      default: ;
    endcase
  endfunction

  function int unsigned round_count();
    int unsigned r;
    r = rounds_reg;
    if (r < 1) r = 1;
    if (r > MAX_RND) r = MAX_RND;
    return r;
  endfunction

  // blocks may only use table entries written by the last expand
  function bit blocks_allowed();
    return table_valid && (round_count() <= expanded_rounds);
  endfunction

  function int unsigned pending();
    return expected_results.size();
  endfunction

  function logic [31:0] rotl(logic [31:0] v, logic [4:0] n);
    if (n == 0) return v;
    return (v << n) | (v >> (32 - int'(n)));
  endfunction

  function logic [31:0] rotr(logic [31:0] v, logic [4:0] n);
    if (n == 0) return v;
    return (v >> n) | (v << (32 - int'(n)));
  endfunction

  function void expand_subkeys();
    int unsigned t, steps, i, j;
    logic [31:0] a, b, sum;
    t     = 2 * (round_count() + 1);
    steps = 3 * ((t > rc5_pkg::KEY_WORDS) ? t : rc5_pkg::KEY_WORDS);
    a = '0;
    b = '0;
    i = 0;
    j = 0;
    foreach (mix_words[k]) mix_words[k] = key_regs[k];
    subkeys[0] = rc5_pkg::RC5_P;
    for (int k = 1; k < t; k++) subkeys[k] = subkeys[k-1] + rc5_pkg::RC5_Q;
    for (int k = 0; k < steps; k++) begin
      a = rotl(subkeys[i] + a + b, rc5_pkg::MIX_A_ROT);
      subkeys[i] = a;
      sum = a + b;
      b = rotl(mix_words[j] + sum, sum[4:0]);
      mix_words[j] = b;
      i = (i + 1 == t) ? 0 : i + 1;
      j = (j + 1) % rc5_pkg::KEY_WORDS;
    end
    table_valid     = 1;
    expanded_rounds = round_count();
  endfunction

  // predicts the result of one accepted command and queues it
  function cipher_result_t note_command(logic [1:0] cmd, logic [31:0] l, logic [31:0] r);
    cipher_result_t res;
    int unsigned    n;
    logic [31:0]    a, b;
    n = round_count();
    a = l;
    b = r;
    if (cmd == rc5_pkg::CMD_EXPAND) begin
      expand_subkeys();
      a = '0;
      b = '0;
    end else if (cmd == rc5_pkg::CMD_ENCRYPT) begin
      a = a + subkeys[0];
      b = b + subkeys[1];
      for (int k = 1; k <= n; k++) begin
        a = rotl(a ^ b, b[4:0]) + subkeys[2*k];
        b = rotl(b ^ a, a[4:0]) + subkeys[2*k+1];
      end
    end else if (cmd == rc5_pkg::CMD_DECRYPT) begin
      for (int k = n; k >= 1; k--) begin
        b = rotr(b - subkeys[2*k+1], a[4:0]) ^ a;
        a = rotr(a - subkeys[2*k], b[4:0]) ^ b;
      end
      b = b - subkeys[1];
      a = a - subkeys[0];
    end else begin
      a = '0;
      b = '0;
    end
    res.left      = a;
    res.right     = b;
    res.key_ready = table_valid;
    expected_results.insert(expected_results.size(), res);
    return res;
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  task check_result(logic [63:0] data, logic ready);
    cipher_result_t want;
    if (expected_results.size() == 0) begin
      report("result with nothing pending (left word)", data[31:0], '0);
    end else begin
      want = expected_results.pop_front();
      results_checked++;
      if (data[31:0] !== want.left) report("left_out", data[31:0], want.left);
      if (data[63:32] !== want.right) report("right_out", data[63:32], want.right);
      if (ready !== want.key_ready) report("key_ready", 32'(ready), 32'(want.key_ready));
    end
  endtask
endclass

module testbench;
  import rc5_pkg::*;

  localparam logic [CMD_W-1:0]       CMD_UNUSED   = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd5;
  localparam int                     STALL_LIMIT  = 3000;
  localparam int                     HOLD_CYCLES  = 400;
  localparam int                     RANDOM_ITEMS = 450;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [WORD_W-1:0]      cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [2*WORD_W-1:0]    s_tdata;
  logic [CMD_W-1:0]       s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [2*WORD_W-1:0]    m_tdata;
  logic                   m_tuser;

  cipher_scoreboard sb;
  bit               tx_quiet;
  bit               rx_quiet;
  int               hold_request;
  int               hold_taken;
  int               hold_left;
  int               idle_cycles;
  int unsigned      n_expand, n_encrypt, n_decrypt, n_unused, n_settings, n_items;
  logic [31:0]      last_left, last_right;

  rc5_block_cipher #(.MAX_ROUNDS(12)) dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 32'd1 << $urandom_range(31);
      3: return ~(32'd1 << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_wr_en <= 1'b0;
    n_settings++;
    @(posedge clk);
  endtask

  // round count goes into the low nibble; the upper bits carry junk
  task automatic write_rounds(logic [3:0] r);
    write_reg(REG_ROUNDS, ($urandom & 32'hFFFF_FFF0) | 32'(r));
  endtask

  task automatic send(logic [CMD_W-1:0] cmd, logic [31:0] l, logic [31:0] r);
    cipher_result_t res;
    if (!tx_quiet && $urandom_range(99) < 34) begin
      s_tvalid <= 1'b0;
      repeat (($urandom_range(3) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 3))
        @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {r, l};
    do @(posedge clk); while (!s_tready);
    res = sb.note_command(cmd, l, r);
    n_items++;
    case (cmd)
      CMD_EXPAND: n_expand++;
      CMD_ENCRYPT: begin
        n_encrypt++;
        last_left  = res.left;
        last_right = res.right;
      end
      CMD_DECRYPT: n_decrypt++;
      default: n_unused++;
    endcase
  endtask

  // all results back means the block is idle again
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_settings();
    int pick;
    for (int k = 0; k < KEY_WORDS; k++)
      if ($urandom_range(1)) write_reg(CFG_INDEX_W'(k), pick_word());
    pick = $urandom_range(9);
    case (pick)
      0: write_rounds(4'd0);
      1: write_rounds(4'd1);
      2: write_rounds(4'd12);
      3: write_rounds(4'(13 + $urandom_range(2)));
      4, 5: write_rounds(4'($urandom_range(2, 11)));
      default: ;
    endcase
    if ($urandom_range(7) == 0) write_reg(REG_UNMAPPED + CFG_INDEX_W'($urandom_range(2)), $urandom);
    end_writes();
  endtask

  task automatic random_run(int count);
    int roll;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      if (!sb.blocks_allowed())
        send((roll < 15) ? CMD_UNUSED : CMD_EXPAND, pick_word(), pick_word());
      else if (roll < 7)
        send(CMD_EXPAND, pick_word(), pick_word());
      else if (roll < 12)
        send(CMD_UNUSED, pick_word(), pick_word());
      else if (roll < 56)
        send(CMD_ENCRYPT, pick_word(), pick_word());
      else if (roll < 72)
        send(CMD_DECRYPT, last_left, last_right);  // round trip of the last cipher text
      else
        send(CMD_DECRYPT, pick_word(), pick_word());
    end
  endtask

  // result side: check, then choose next ready
  initial begin
    hold_left  = 0;
    hold_taken = 0;
    m_tready   = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if (hold_request != hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = hold_request;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= rx_quiet || ($urandom_range(99) >= 34);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int phase_no;
    sb           = new();
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    tx_quiet     = 0;
    rx_quiet     = 0;
    hold_request = 0;
    last_left    = '0;
    last_right   = '0;
    n_expand = 0; n_encrypt = 0; n_decrypt = 0; n_unused = 0; n_settings = 0; n_items = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: zero key, twelve rounds; unused command before any expand
    send(CMD_UNUSED, '1, '1);
    send(CMD_EXPAND, '1, '0);
    send(CMD_ENCRYPT, '0, '0);
    send(CMD_ENCRYPT, '1, '1);
    send(CMD_DECRYPT, last_left, last_right);
    send(CMD_UNUSED, 32'h8000_0001, 32'h7FFF_FFFE);
    drain();

    for (int k = 0; k < KEY_WORDS; k++) write_reg(CFG_INDEX_W'(k), '1);
    write_rounds(4'd12);
    end_writes();
    send(CMD_EXPAND, '0, '0);
    send(CMD_ENCRYPT, '1, '0);
    send(CMD_DECRYPT, '0, '1);
    drain();

    for (int k = 0; k < KEY_WORDS; k++) write_reg(CFG_INDEX_W'(k), $urandom);
    write_rounds(4'd1);
    end_writes();
    send(CMD_EXPAND, '0, '0);
    send(CMD_ENCRYPT, $urandom, $urandom);
    send(CMD_DECRYPT, $urandom, $urandom);
    drain();

    // zero rounds behaves as one
    write_rounds(4'd0);
    end_writes();
    send(CMD_EXPAND, '0, '0);
    send(CMD_ENCRYPT, $urandom, $urandom);
    drain();

    // above the maximum behaves as the maximum
    write_rounds(4'd15);
    end_writes();
    send(CMD_EXPAND, '0, '0);
    send(CMD_ENCRYPT, $urandom, $urandom);
    send(CMD_DECRYPT, last_left, last_right);
    drain();

    // new key without expand: old table stays in use
    write_reg(REG_KEY_WORD_0, 32'h0123_4567);
    write_reg(REG_KEY_WORD_2, '0);
    write_reg(REG_UNMAPPED, '1);
    end_writes();
    send(CMD_ENCRYPT, $urandom, $urandom);
    send(CMD_DECRYPT, $urandom, $urandom);
    drain();

    // fewer rounds than the table was built for
    write_rounds(4'd3);
    end_writes();
    send(CMD_ENCRYPT, $urandom, $urandom);
    send(CMD_DECRYPT, last_left, last_right);
    send(CMD_UNUSED, '0, '0);
    send(CMD_EXPAND, '0, '0);
    send(CMD_ENCRYPT, '0, '1);
    drain();

    phase_no = 0;
    while (n_items < 24 + RANDOM_ITEMS) begin
      random_settings();
      tx_quiet = 0;
      rx_quiet = 0;
      if (phase_no == 3) begin
        // receiver backs off while the sender keeps offering
        tx_quiet = 1;
        hold_request++;
        random_run(12);
      end else if (phase_no == 6) begin
        tx_quiet = 1;
        rx_quiet = 1;
        random_run(60);
      end else begin
        random_run($urandom_range(8, 40));
      end
      drain();
      phase_no++;
    end
    tx_quiet = 0;
    rx_quiet = 0;

    repeat (40) @(posedge clk);
    if (sb.pending() != 0) sb.report("results never delivered", sb.pending(), '0);

    $display("covered %0d expand, %0d encrypt, %0d decrypt, %0d unused commands", n_expand,
             n_encrypt, n_decrypt, n_unused);
    $display("across %0d settings; %0d results compared, %0d mismatches", n_settings,
             sb.results_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
